@@ rtl/dssw_pkg.sv @@
`default_nettype none
package dssw_pkg;

  localparam int MAX_DIGITS_DEFAULT = 5;
  localparam int VALUE_W = 16;
  localparam int ADDR_W = 8;
  localparam int PATTERN_W = 7;
  localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = 8'd146;

  // Reciprocal of ten: (v * 52429) >> 19 equals v / 10 for every 16-bit v
  localparam logic [16:0] RECIP_TEN = 17'd52429;
  localparam int RECIP_SHIFT = 19;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   quotient;
    logic                 quotient_zero;
    logic [PATTERN_W-1:0] pattern;
  } digit_t;

  function automatic logic [PATTERN_W-1:0] seg_pattern(input logic [3:0] digit);
    logic [PATTERN_W-1:0] pat;
    unique case (digit)
      4'd0:    pat = 7'h5F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h6B;
      4'd3:    pat = 7'h2F;
      4'd4:    pat = 7'h36;
      4'd5:    pat = 7'h3D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h3F;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

@@ rtl/dssw_div10.sv @@
`default_nettype none
module dssw_div10 (
  input  wire logic [dssw_pkg::VALUE_W-1:0] work,
  output dssw_pkg::digit_t                  digit
);
  import dssw_pkg::*;

  logic [VALUE_W+16:0]  product;
  logic [VALUE_W-1:0]   quotient;
  logic [VALUE_W-1:0]   times_ten;
  logic [VALUE_W-1:0]   remainder;

  always_comb begin
    product   = (VALUE_W+17)'(work) * (VALUE_W+17)'(RECIP_TEN);
    quotient  = VALUE_W'(product >> RECIP_SHIFT);
    // q * 10 as q * 8 + q * 2
    times_ten = (quotient << 3) + (quotient << 1);
    remainder = work - times_ten;

    digit.quotient      = quotient;
    digit.quotient_zero = (quotient == '0);
    digit.pattern       = seg_pattern(remainder[3:0]);
  end

endmodule
`default_nettype wire

@@ rtl/dssw_seq.sv @@
`default_nettype none
module dssw_seq #(
  parameter int MAX_DIGITS = dssw_pkg::MAX_DIGITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [dssw_pkg::VALUE_W-1:0]   value,
  input  wire logic                           write_enable,
  input  wire logic [dssw_pkg::ADDR_W-1:0]    write_data,
  input  wire dssw_pkg::digit_t               digit,
  output logic [dssw_pkg::VALUE_W-1:0]        work,
  output logic                                busy,
  output logic                                segment_write,
  output logic [dssw_pkg::ADDR_W-1:0]         segment_address,
  output logic [dssw_pkg::PATTERN_W-1:0]      segment_pattern,
  output logic                                last_write
);
  import dssw_pkg::*;

  localparam int POS_W = $clog2(MAX_DIGITS + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_DIGITS);

  seq_state_t         state;
  seq_state_t         state_next;
  logic [POS_W-1:0]   position;
  logic [ADDR_W-1:0]  base_address;
  logic               accept;
  logic               final_digit;

  assign accept      = start && !busy;
  assign final_digit = digit.quotient_zero || (position == POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state == SEQ_RUN);
    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (final_digit) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_ADDRESS_RESET;
    end else if (write_enable) begin
      base_address <= write_data;
    end
  end

  // Load the request, then strip one digit per cycle through the shared divider
  always_ff @(posedge clk) begin
    if (accept) begin
      work     <= value;
      position <= POS_W'(1);
    end else if (busy) begin
      work     <= digit.quotient;
      position <= position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_write <= 1'b0;
      last_write    <= 1'b0;
    end else begin
      segment_write <= busy;
      last_write    <= busy && final_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      segment_address <= base_address + ADDR_W'(position);
      segment_pattern <= digit.pattern;
    end
  end

endmodule
`default_nettype wire

@@ rtl/decimal_seven_segment_writer.sv @@
`default_nettype none
// Decimal seven-segment writer.
// Request channel: raise start with value; the request is taken on a rising
// edge where start is high and busy is low. busy stays high while digits are
// being produced and no new request is taken meanwhile.
// Result channel: one write per decimal digit, units digit first. Each write
// is shown for exactly one cycle with segment_write high; segment_address is
// the base register plus the digit position (1 for units), segment_pattern is
// the seven-segment code, and last_write marks the most significant digit.
// Timing: a request is registered as the working value, and each digit write
// is then registered from the divider output, one write per cycle; busy
// stays high until the last digit is produced, and a new request is taken
// only after busy falls. The rate is set by the single divide-by-ten unit,
// which yields one digit per cycle. At most MAX_DIGITS writes per value.
// The base register is loaded whenever write_enable is high.
// Reset (rst, synchronous) returns the sequencer to idle, drops any pending
// writes and sets the base register to 146. The receiver cannot stall.
module decimal_seven_segment_writer #(
  parameter int MAX_DIGITS = dssw_pkg::MAX_DIGITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [dssw_pkg::VALUE_W-1:0]   value,
  input  wire logic                           write_enable,
  input  wire logic [dssw_pkg::ADDR_W-1:0]    write_data,
  output logic                                segment_write,
  output logic [dssw_pkg::ADDR_W-1:0]         segment_address,
  output logic [dssw_pkg::PATTERN_W-1:0]      segment_pattern,
  output logic                                last_write
);
  import dssw_pkg::*;

  logic [VALUE_W-1:0] work;
  digit_t             digit;

  dssw_div10 u_div10 (
    .work  (work),
    .digit (digit)
  );

  dssw_seq #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .value           (value),
    .write_enable    (write_enable),
    .write_data      (write_data),
    .digit           (digit),
    .work            (work),
    .busy            (busy),
    .segment_write   (segment_write),
    .segment_address (segment_address),
    .segment_pattern (segment_pattern),
    .last_write      (last_write)
  );

`ifndef SYNTHESIS
  a_write_follows_busy: assert property (@(posedge clk) disable iff (rst)
    segment_write |-> $past(busy))
    else $error("digit write without a running conversion");

  a_request_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start a conversion");

  a_last_is_write: assert property (@(posedge clk) disable iff (rst)
    last_write |-> segment_write)
    else $error("last flag without a write");

  a_digits_contiguous: assert property (@(posedge clk) disable iff (rst)
    (segment_write && !last_write) |=> segment_write)
    else $error("digit sequence broken before its last write");
`endif

endmodule
`default_nettype wire

@@ test/dssw_checker.sv @@
`timescale 1ns / 1ps

module dssw_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [dssw_pkg::VALUE_W-1:0]    value,
  input  logic                            write_enable,
  input  logic [dssw_pkg::ADDR_W-1:0]     write_data,
  input  logic                            segment_write,
  input  logic [dssw_pkg::ADDR_W-1:0]     segment_address,
  input  logic [dssw_pkg::PATTERN_W-1:0]  segment_pattern,
  input  logic                            last_write,
  output int                              fail_count,
  output int                              writes_pending
);
  import dssw_pkg::*;

  localparam int MAX_DIGITS = MAX_DIGITS_DEFAULT;
  // Segment codes for digits 9 down to 0, packed
  localparam logic [10*PATTERN_W-1:0] SEGMENT_ROM = {
    7'h3F, 7'h7F, 7'h07, 7'h7D, 7'h3D, 7'h36, 7'h2F, 7'h6B, 7'h06, 7'h5F
  };

  typedef struct packed {
    logic [ADDR_W-1:0]    address;
    logic [PATTERN_W-1:0] pattern;
    logic                 last;
  } digit_write_t;

  digit_write_t digit_writes_due[$];
  logic [ADDR_W-1:0] base_address;
  int reports;

  initial begin
    fail_count = 0;
    writes_pending = 0;
    reports = 0;
    base_address = BASE_ADDRESS_RESET;
  end

  function automatic void expect_digit_writes(input logic [VALUE_W-1:0] number);
    int unsigned rest;
    int unsigned digits;
    int unsigned bound;
    int unsigned d;
    digit_write_t w;
    rest = number;
    digits = 1;
    bound = 10;
    while (rest >= bound && digits < MAX_DIGITS) begin
      digits++;
      bound = bound * 10;
    end
    for (int k = 1; k <= digits; k++) begin
      d = rest % 10;
      w.address = base_address + ADDR_W'(k);
      w.pattern = SEGMENT_ROM[d*PATTERN_W +: PATTERN_W];
      w.last = (k == digits);
      digit_writes_due.push_back(w);
      rest = rest / 10;
    end
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (reports < 10) begin
      reports++;
      $display("%0t: %s", $realtime, what);
    end
  endtask

  always @(posedge clk) begin
    digit_write_t want;
    if (rst) begin
      digit_writes_due.delete();
      base_address = BASE_ADDRESS_RESET;
    end else begin
      // Check the write first: a new request only joins the back of the queue
      if (segment_write) begin
        if (digit_writes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected write addr %0d pattern %h last %b",
                                    segment_address, segment_pattern, last_write));
        end else begin
          want = digit_writes_due.pop_front();
          if (segment_address !== want.address)
            report_mismatch($sformatf("address: expected %0d, got %0d",
                                      want.address, segment_address));
          if (segment_pattern !== want.pattern)
            report_mismatch($sformatf("pattern: expected %h, got %h",
                                      want.pattern, segment_pattern));
          if (last_write !== want.last)
            report_mismatch($sformatf("last_write: expected %b, got %b",
                                      want.last, last_write));
        end
      end
      if (start && !busy)
        expect_digit_writes(value);
      if (write_enable)
        base_address = write_data;
    end
    writes_pending = digit_writes_due.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import dssw_pkg::*;

  localparam int CYCLE_LIMIT = 60000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [VALUE_W-1:0]   value;
  logic                 write_enable;
  logic [ADDR_W-1:0]    write_data;
  logic                 segment_write;
  logic [ADDR_W-1:0]    segment_address;
  logic [PATTERN_W-1:0] segment_pattern;
  logic                 last_write;
  int                   fail_count;
  int                   writes_pending;

  decimal_seven_segment_writer dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .value           (value),
    .write_enable    (write_enable),
    .write_data      (write_data),
    .segment_write   (segment_write),
    .segment_address (segment_address),
    .segment_pattern (segment_pattern),
    .last_write      (last_write)
  );

  dssw_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .value           (value),
    .write_enable    (write_enable),
    .write_data      (write_data),
    .segment_write   (segment_write),
    .segment_address (segment_address),
    .segment_pattern (segment_pattern),
    .last_write      (last_write),
    .fail_count      (fail_count),
    .writes_pending  (writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top failed");
    $finish;
  end

  task automatic send_request(input logic [VALUE_W-1:0] number);
    @(negedge clk);
    start <= 1'b1;
    value <= number;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Drop start and wait for every digit write to come out
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (writes_pending != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] base);
    drain();
    write_enable <= 1'b1;
    write_data <= base;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  logic [VALUE_W-1:0] directed [$];
  logic [ADDR_W-1:0]  bases [$];
  logic [VALUE_W-1:0] number;
  int                 item;

  initial begin
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    write_enable = 1'b0;
    write_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Length boundaries, all ten digits, and alternating bit patterns
    directed = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
                 16'd9999, 16'd10000, 16'd65535, 16'd12345, 16'd67890,
                 16'h5555, 16'hAAAA, 16'h8000, 16'd1, 16'd11, 16'd101,
                 16'd50000, 16'd7};
    foreach (directed[i]) send_request(directed[i]);

    // Extremes and wrap-around of the base, then random settings
    bases = '{8'd255, 8'd0, 8'd251, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255))};
    item = 0;
    foreach (bases[p]) begin
      write_base(bases[p]);
      for (int n = 0; n < 38; n++) begin
        case ($urandom_range(0, 9))
          0: number = 16'($urandom_range(0, 9));
          1: number = 16'($urandom_range(10, 99));
          2: number = 16'($urandom_range(100, 999));
          3: number = 16'($urandom_range(1000, 9999));
          4: number = (16'd1 << $urandom_range(0, 15)) ^ 16'($urandom_range(0, 1));
          5: begin
            case ($urandom_range(0, 3))
              0: number = 16'd10;
              1: number = 16'd100;
              2: number = 16'd1000;
              default: number = 16'd10000;
            endcase
            number = number - 16'($urandom_range(0, 1));
          end
          default: number = 16'($urandom);
        endcase
        send_request(number);
        // Keep a long run of back-to-back requests in the middle
        if ((item < 60 || item > 130) && $urandom_range(0, 99) < 12)
          hold_off($urandom_range(1, 6));
        if (item == 150)
          drain();
        item++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
